[rtl/core/cfa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and command/status types for the contiguous frame allocator.
// Used by cfa_ctrl, cfa_datapath and the top level; depends on nothing else.
package cfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FRAME_W    = 20;
    localparam int ENTRY_W    = CNT_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_FIRST_FRAME = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write one reset entry during the clearing pass
        logic load;       // capture an input beat
        logic scan;       // one step of the first-fit scan
        logic alloc_wr;   // mark one frame of the found run as used
        logic free_rd;    // read the stored run length of the freed frame
        logic free_len;   // turn the run length into the last frame to free
        logic free_wr;    // release one frame
        logic out_load;   // load the output register
        logic out_ok;     // result status of the beat being loaded
    } cfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic in_kind;
        logic in_want_zero;
        logic in_range;
        logic scan_found;
        logic scan_fail;
        logic fill_done;
        logic out_free;
    } cfa_status_t;

endpackage

[rtl/core/cfa_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the contiguous frame allocator.
// Depends on cfa_pkg for the command and status types.
module cfa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cfa_pkg::cfa_status_t st,
    output cfa_pkg::cfa_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_SCAN       = 8'b0000_0100,
        S_ALLOC_FILL = 8'b0000_1000,
        S_FREE_RD    = 8'b0001_0000,
        S_FREE_LEN   = 8'b0010_0000,
        S_FREE_FILL  = 8'b0100_0000,
        S_RESP       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (st.in_kind == cfa_pkg::KIND_FREE)
                    begin
                        state_next = S_FREE_RD;
                    end
                    else if (st.in_want_zero)
                    begin
                        ok_next    = 1'b0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_found)
                begin
                    state_next = S_ALLOC_FILL;
                end
                else if (st.scan_fail)
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_ALLOC_FILL:
            begin
                cmd.alloc_wr = 1'b1;
                if (st.fill_done)
                begin
                    ok_next    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_FREE_RD:
            begin
                if (st.in_range)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_LEN;
                end
                else
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_FREE_LEN:
            begin
                cmd.free_len = 1'b1;
                state_next   = S_FREE_FILL;
            end
            S_FREE_FILL:
            begin
                cmd.free_wr = 1'b1;
                if (st.fill_done)
                begin
                    ok_next    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // Hold the result here until the output register can take it.
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

endmodule

[rtl/core/cfa_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the contiguous frame allocator: frame table memory, scan and
// fill counters, configuration registers and the output register. Uses cfa_pkg.
module cfa_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cfa_pkg::FRAME_W-1:0]   cfg_data,
    input  logic                          kind,
    input  logic [cfa_pkg::CNT_W-1:0]     page_count,
    input  logic [cfa_pkg::FRAME_W-1:0]   frame_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [cfa_pkg::FRAME_W-1:0]   start_frame,
    input  cfa_pkg::cfa_cmd_t             cmd,
    output cfa_pkg::cfa_status_t          st
);

    localparam int IDX_W   = cfa_pkg::IDX_W;
    localparam int CNT_W   = cfa_pkg::CNT_W;
    localparam int FRAME_W = cfa_pkg::FRAME_W;
    localparam int ENTRY_W = cfa_pkg::ENTRY_W;
    localparam int SUM_W   = CNT_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(cfa_pkg::MAX_FRAMES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(cfa_pkg::MAX_FRAMES - 1);

    // Each entry holds {used, run length}.
    logic [ENTRY_W-1:0] mem [0:cfa_pkg::MAX_FRAMES-1];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;

    logic [FRAME_W-1:0] first_frame_reg;
    logic [CNT_W-1:0]   frame_count_reg;
    logic [CNT_W-1:0]   n_frames;

    logic               kind_reg;
    logic [CNT_W-1:0]   want_reg;
    logic               in_range_reg;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [IDX_W-1:0]   base_reg, base_next;

    logic               out_valid_reg, out_valid_next;
    logic               status_reg;
    logic [FRAME_W-1:0] start_reg;

    logic [FRAME_W-1:0] in_idx;
    logic               in_range;
    logic               issue;
    logic               entry_used;
    logic [CNT_W-1:0]   run_inc;
    logic               found;
    logic [IDX_W-1:0]   base_calc;
    logic [SUM_W-1:0]   free_sum;
    logic [SUM_W-1:0]   free_lim;

    assign n_frames = (frame_count_reg > MAX_CNT) ? MAX_CNT : frame_count_reg;

    // Frame numbers wrap modulo 2^20, so the index is a plain wrapped subtract.
    assign in_idx   = frame_number - first_frame_reg;
    assign in_range = (in_idx < FRAME_W'(n_frames));

    assign issue      = (addr_reg < n_frames);
    assign entry_used = rd_data_reg[ENTRY_W-1];
    assign run_inc    = run_reg + CNT_W'(1);
    assign found      = pend_valid_reg && !entry_used && (run_inc == want_reg);
    assign base_calc  = IDX_W'({1'b0, pend_idx_reg} + CNT_W'(1) - want_reg);

    assign free_sum = SUM_W'(addr_reg[IDX_W-1:0]) + SUM_W'(rd_data_reg[CNT_W-1:0]);
    assign free_lim = (free_sum > SUM_W'(n_frames)) ? SUM_W'(n_frames) : free_sum;

    assign st.clr_last     = (addr_reg[IDX_W-1:0] == LAST_IDX);
    assign st.in_kind      = kind;
    assign st.in_want_zero = (page_count == '0);
    assign st.in_range     = in_range_reg;
    assign st.scan_found   = found;
    assign st.scan_fail    = !pend_valid_reg && !issue;
    assign st.fill_done    = (addr_reg[IDX_W-1:0] == end_reg);
    assign st.out_free     = !out_valid_reg || !out_stall;

    assign mem_we    = cmd.clr_step || cmd.alloc_wr || cmd.free_wr;
    assign mem_waddr = addr_reg[IDX_W-1:0];
    assign mem_wdata = cmd.alloc_wr ? {1'b1, want_reg} : {1'b0, CNT_W'(1)};
    assign mem_re    = cmd.scan || cmd.free_rd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        addr_next       = addr_reg;
        run_next        = run_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        end_next        = end_reg;
        base_next       = base_reg;
        if (cmd.load)
        begin
            run_next        = '0;
            pend_valid_next = 1'b0;
            if (kind == cfa_pkg::KIND_FREE)
            begin
                addr_next = CNT_W'(in_idx[IDX_W-1:0]);
            end
            else
            begin
                addr_next = '0;
            end
        end
        else if (cmd.scan)
        begin
            if (pend_valid_reg)
            begin
                run_next = entry_used ? '0 : run_inc;
            end
            if (found)
            begin
                // Run complete: rewind to its first frame for the fill.
                addr_next = CNT_W'(base_calc);
                base_next = base_calc;
                end_next  = pend_idx_reg;
            end
            else if (issue)
            begin
                addr_next       = addr_reg + CNT_W'(1);
                pend_valid_next = 1'b1;
                pend_idx_next   = addr_reg[IDX_W-1:0];
            end
            else
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (cmd.free_len)
        begin
            end_next = IDX_W'(free_lim - SUM_W'(1));
        end
        else if (cmd.clr_step || cmd.alloc_wr || cmd.free_wr)
        begin
            addr_next = addr_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= '0;
            frame_count_reg <= '0;
            addr_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == cfa_pkg::REG_FIRST_FRAME)
                begin
                    first_frame_reg <= cfg_data;
                end
                else
                begin
                    frame_count_reg <= cfg_data[CNT_W-1:0];
                end
            end
            addr_reg       <= addr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind;
            want_reg     <= page_count;
            in_range_reg <= in_range;
        end
        run_reg      <= run_next;
        pend_idx_reg <= pend_idx_next;
        end_reg      <= end_next;
        base_reg     <= base_next;
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_ok ? cfa_pkg::STATUS_OK : cfa_pkg::STATUS_FAIL;
            if (cmd.out_ok && (kind_reg == cfa_pkg::KIND_ALLOC))
            begin
                start_reg <= first_frame_reg + FRAME_W'(base_reg);
            end
            else
            begin
                start_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_frame = start_reg;

endmodule

[rtl/core/contiguous_frame_allocator_unit.sv]
`timescale 1ns / 1ps
// First-fit contiguous page frame allocator. Top level that joins the
// controller (cfa_ctrl) and the datapath (cfa_datapath); uses cfa_pkg.
//
// Usage: the request channel (in_valid/in_stall) carries one beat per
// request: kind 0 allocates page_count consecutive free frames, kind 1 frees
// the run that starts at frame_number. The result channel (out_valid/
// out_stall) returns one beat per request with status and start_frame.
// first_frame and frame_count are set through cfg_we/cfg_index/cfg_data,
// by the user while no request is in flight; the block does not check it.
// Operation: an allocate scans the frames in order through the single read
// port of the frame table until a free run of page_count frames is found,
// then marks each frame of the run as used and loads the output register;
// a failed allocate scans all managed frames. A free reads the run length,
// finds its last frame and frees those frames one by one. One request is
// in progress at a time; in_stall is low only while the block is idle.
// Reset: after rst_n rises every entry of the frame table is cleared, one
// entry per cycle, with in_stall high; configuration writes are taken then.
// A stalled result is held in the output register, and the block still
// takes and works on the next request, holding its result until taken.
module contiguous_frame_allocator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cfa_pkg::FRAME_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [cfa_pkg::CNT_W-1:0]     page_count,
    input  logic [cfa_pkg::FRAME_W-1:0]   frame_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [cfa_pkg::FRAME_W-1:0]   start_frame
);

    cfa_pkg::cfa_cmd_t    cmd;
    cfa_pkg::cfa_status_t st;

    cfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    cfa_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .page_count   (page_count),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .start_frame  (start_frame),
        .cmd          (cmd),
        .st           (st)
    );

endmodule
